// ===== hdl/oaht_pkg.sv =====
package oaht_pkg;

   localparam int KEY_W = 32;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_ABSENT = 2'd1,
      ST_FULL   = 2'd2,
      ST_LIMIT  = 2'd3
   } status_type;

   localparam logic [KEY_W-1:0] EMPTY_KEY = '1;
   localparam logic [7:0] LATE_FIRST = 8'd21;
   localparam logic [7:0] LATE_END = 8'd200;

   // hash constants
   localparam logic [31:0] H_A0 = 32'd72345219;
   localparam logic [31:0] H_A1 = 32'd233878732;
   localparam logic [31:0] H_A2 = 32'd777;
   localparam logic [31:0] H_B0 = 32'd123456789;
   localparam logic [31:0] H_B1 = 32'd7654321;
   localparam logic [31:0] H_C0 = 32'd9234569;
   localparam logic [31:0] H_C1 = 32'd12345671;
   localparam logic [31:0] H_D1 = 32'd5163151;
   localparam logic [31:0] H_E0 = 32'd314159265;
   localparam logic [31:0] H_E1 = 32'd755332;

   // classified item passed from front to back
   typedef struct packed {
      action_type        action;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
      logic [31:0]       hash;
   } item_type;

endpackage

// ===== hdl/oaht_if.sv =====
interface oaht_req_if;
   import oaht_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic [KEY_W-1:0]  key;
   logic [DATA_W-1:0] data_in;
   modport source (output valid, action, key, data_in, input ready);
   modport sink (input valid, action, key, data_in, output ready);
endinterface

interface oaht_rsp_if;
   import oaht_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [DATA_W-1:0] data_out;
   modport source (output valid, status, data_out, input ready);
   modport sink (input valid, status, data_out, output ready);
endinterface

// ===== hdl/open_address_hash_table_core.sv =====
// A request passes the hash pipeline (6 hash stages), the queue, the probe loop (states
// S_READ and S_CHECK per probe) and S_DONE, which presents the response; a lookup hit adds S_VAL.
// The probe loop handles one item at a time and takes no new item until the response transfers.
// Reset (synchronous, active high) starts a clearing pass over every slot of the key memory,
// during which no item leaves the queue.
module open_address_hash_table_core import oaht_pkg::*; #(
   parameter int TABLE_SIZE = 1024,
   parameter int INSERT_PROBES = 30
) (
   input  logic clock,
   input  logic reset,
   oaht_req_if.sink   req,
   oaht_rsp_if.source rsp
);

   item_type req_item, h_item, q_item;
   logic     h_valid, h_ready, q_valid, q_ready;

   always_comb begin
      req_item.action = action_type'(req.action);
      req_item.key = req.key;
      req_item.data = req.data_in;
      req_item.hash = '0;
   end

   oaht_hash u_hash (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_item(req_item),
      .out_valid(h_valid), .out_ready(h_ready), .out_item(h_item)
   );

   oaht_queue #(.DEPTH(4)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(h_valid), .in_ready(h_ready), .in_item(h_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   oaht_probe #(.TABLE_SIZE(TABLE_SIZE), .INSERT_PROBES(INSERT_PROBES)) u_probe (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_status(rsp.status), .out_data(rsp.data_out)
   );

endmodule

// ===== hdl/oaht_hash.sv =====
// Front part: pipelined multiply-mix hash, one multiply level per stage.
module oaht_hash import oaht_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int NS = 6;

   logic [NS-1:0] vld_ff;
   item_type      it_ff [NS];
   logic [31:0]   a_ff [NS];
   logic [31:0]   b_ff [NS];
   logic [31:0]   c_ff [NS];
   logic [31:0]   d_ff [NS];
   logic [31:0]   t_ff [NS];
   logic [31:0]   u_ff [NS];
   logic          adv;

   assign adv = !vld_ff[NS-1] || out_ready;
   assign in_ready = adv;
   assign out_valid = vld_ff[NS-1];

   // fold e and its high half into the partial sum
   always_comb begin
      out_item = it_ff[NS-1];
      out_item.hash = t_ff[NS-1] + u_ff[NS-1] + (u_ff[NS-1] >> 16);
   end

   // advance the whole pipe together
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      logic [31:0] k;
      k = 32'd0;
      if (adv) begin
         // stage 0: k*k, k*A1
         it_ff[0] <= in_item;
         t_ff[0] <= in_item.key * in_item.key;
         u_ff[0] <= in_item.key * H_A1;
         // stage 1: a
         k = it_ff[0].key;
         it_ff[1] <= it_ff[0];
         a_ff[1] <= H_A0 + u_ff[0] + H_A2 * t_ff[0] + (k >> 8);
         // stage 2: b, k*a
         k = it_ff[1].key;
         it_ff[2] <= it_ff[1];
         a_ff[2] <= a_ff[1];
         b_ff[2] <= H_B0 + a_ff[1] * H_B1 + (a_ff[1] >> 8);
         t_ff[2] <= k * a_ff[1];
         // stage 3: c
         it_ff[3] <= it_ff[2];
         a_ff[3] <= a_ff[2];
         b_ff[3] <= b_ff[2];
         c_ff[3] <= H_C0 + b_ff[2] * H_C1 + t_ff[2] + (b_ff[2] >> 16);
         // stage 4: d, c*k, b*c
         k = it_ff[3].key;
         it_ff[4] <= it_ff[3];
         a_ff[4] <= a_ff[3];
         b_ff[4] <= b_ff[3];
         c_ff[4] <= c_ff[3];
         d_ff[4] <= ((k + c_ff[3]) >> 8) * H_D1 + b_ff[3] * c_ff[3] + (c_ff[3] >> 8);
         t_ff[4] <= c_ff[3] * k;
         // stage 5: e and partial sum
         k = it_ff[4].key;
         it_ff[5] <= it_ff[4];
         u_ff[5] <= ((H_E0 + 32'd7 * a_ff[4] + d_ff[4] * H_E1) >> 16)
                    + t_ff[4] * b_ff[4];
         t_ff[5] <= k + a_ff[4] + b_ff[4] + c_ff[4] + d_ff[4];
      end
      a_ff[0] <= '0;
      b_ff[0] <= '0; b_ff[1] <= '0;
      c_ff[0] <= '0; c_ff[1] <= '0; c_ff[2] <= '0; c_ff[5] <= '0;
      d_ff[0] <= '0; d_ff[1] <= '0; d_ff[2] <= '0; d_ff[3] <= '0; d_ff[5] <= '0;
      a_ff[5] <= '0; b_ff[5] <= '0;
      t_ff[1] <= '0; t_ff[3] <= '0;
      u_ff[1] <= '0; u_ff[2] <= '0; u_ff[3] <= '0; u_ff[4] <= '0;
   end

endmodule

// ===== hdl/oaht_queue.sv =====
// Short queue between front and back parts.
module oaht_queue import oaht_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int AW = $clog2(DEPTH);

   item_type       mem_ff [DEPTH];
   logic [AW-1:0]  wr_ff, rd_ff;
   logic [AW:0]    cnt_ff;
   logic           push, pop;

   assign in_ready = cnt_ff != (AW+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_item = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   // track pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_item;
   end

endmodule

// ===== hdl/oaht_probe.sv =====
// Back part: probe sequencer over the key and value memories.
module oaht_probe import oaht_pkg::*; #(
   parameter int TABLE_SIZE = 1024,
   parameter int INSERT_PROBES = 30
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  item_type          in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [1:0]        out_status,
   output logic [DATA_W-1:0] out_data
);

   localparam int AW = $clog2(TABLE_SIZE);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_CHECK, S_VAL, S_DONE
   } state_type;

   state_type         state_ff;
   logic [KEY_W-1:0]  keys [TABLE_SIZE];
   logic [DATA_W-1:0] vals [TABLE_SIZE];
   logic [KEY_W-1:0]  krd_ff;
   logic [DATA_W-1:0] vrd_ff;
   logic [AW-1:0]     slot_ff, clr_ff;
   logic [7:0]        i_ff;
   logic              late_ff;
   item_type          it_ff;
   logic [1:0]        status_ff;
   logic [DATA_W-1:0] data_ff;
   logic              kwe, vwe, last_i;
   logic [AW-1:0]     kwa, next_slot;
   logic [KEY_W-1:0]  kwd;

   assign in_ready = state_ff == S_IDLE;
   assign out_valid = state_ff == S_DONE;
   assign out_status = status_ff;
   assign out_data = data_ff;

   // distance i+1 wraps modulo a power-of-two table size
   assign next_slot = slot_ff - AW'(i_ff + 8'd1);
   assign last_i = late_ff ? (i_ff == LATE_END - 8'd1)
                           : (i_ff == 8'(INSERT_PROBES - 1));

   // key and value memory write ports: clear sweep, insert, remove
   always_comb begin
      kwe = 1'b0;
      vwe = 1'b0;
      kwa = slot_ff;
      kwd = it_ff.key;
      if (state_ff == S_CLEAR) begin
         kwe = 1'b1;
         kwa = clr_ff;
         kwd = EMPTY_KEY;
      end else if (state_ff == S_CHECK) begin
         if (it_ff.action == ACT_INSERT && krd_ff == EMPTY_KEY) begin
            kwe = 1'b1;
            vwe = 1'b1;
         end else if (it_ff.action == ACT_REMOVE && krd_ff == it_ff.key) begin
            kwe = 1'b1;
            kwd = EMPTY_KEY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (kwe) keys[kwa] <= kwd;
      if (vwe) vals[kwa] <= it_ff.data;
      krd_ff <= keys[slot_ff];
      vrd_ff <= vals[slot_ff];
   end

   // sequence the probes
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         slot_ff <= '0;
         i_ff <= '0;
         late_ff <= 1'b0;
         status_ff <= ST_OK;
         data_ff <= '0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(TABLE_SIZE - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (in_valid) begin
                  it_ff <= in_item;
                  slot_ff <= in_item.hash[AW-1:0];
                  i_ff <= '0;
                  late_ff <= 1'b0;
                  data_ff <= '0;
                  if (in_item.action == ACT_NONE) begin
                     status_ff <= ST_OK;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: state_ff <= S_CHECK;
            S_CHECK: begin
               if (it_ff.action == ACT_INSERT) begin
                  if (krd_ff == EMPTY_KEY) begin
                     status_ff <= ST_OK;
                     state_ff <= S_DONE;
                  end else if (last_i) begin
                     status_ff <= ST_FULL;
                     state_ff <= S_DONE;
                  end else begin
                     slot_ff <= next_slot;
                     i_ff <= i_ff + 8'd1;
                     state_ff <= S_READ;
                  end
               end else if (krd_ff == it_ff.key) begin
                  status_ff <= ST_OK;
                  state_ff <= (it_ff.action == ACT_LOOKUP) ? S_VAL : S_DONE;
               end else if (krd_ff == EMPTY_KEY) begin
                  status_ff <= ST_ABSENT;
                  state_ff <= S_DONE;
               end else begin
                  slot_ff <= next_slot;
                  state_ff <= S_READ;
                  i_ff <= i_ff + 8'd1;
                  if (last_i) begin
                     // late phase starts from the slot after the last step
                     if (it_ff.action == ACT_LOOKUP && !late_ff) begin
                        late_ff <= 1'b1;
                        i_ff <= LATE_FIRST;
                     end else begin
                        status_ff <= ST_LIMIT;
                        state_ff <= S_DONE;
                     end
                  end
               end
            end
            S_VAL: begin
               data_ff <= vrd_ff;
               state_ff <= S_DONE;
            end
            S_DONE: if (out_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
